// ===== rtl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, codes and the multiply-accumulate microprogram of the
// four-anchor trilateration solver.
// ----------------------------------------------------------------------------
package tps_pkg;

  // Field and datapath widths
  localparam int COORD_W   = 16;
  localparam int DIST_W    = 16;
  localparam int POS_W     = 24;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 5;
  localparam int OPND_W    = 36;   // shared multiplier operand width
  localparam int ACC_W     = 2 * OPND_W;
  localparam int DIFF_W    = COORD_W + 1;   // first-row coordinate differences
  localparam int BVAL_W    = 35;   // sphere constants, rhs and cofactors
  localparam int DET_W     = 54;
  localparam int DEN_W     = DET_W + 1;
  localparam int QUO_W     = POS_W + 1;   // quotient bits incl. overflow bit

  localparam int USED_ANCHORS    = 4;
  localparam int DEF_MAX_ANCHORS = 16;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_ENOUGH = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_MANY   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DEGENERATE = 2'd3;

  // Operand source codes
  localparam int SEL_W   = 6;
  localparam int SEL_ANC = 0;    // anchor i field f at SEL_ANC + 4*i + f (f: x y z d)
  localparam int SEL_M   = 16;   // difference m(i,j) at SEL_M + 3*i + j
  localparam int SEL_R   = 25;   // rhs r(i)
  localparam int SEL_COF = 28;   // cofactor(i,k) at SEL_COF + 3*i + k
  localparam int NUM_SRC = 37;

  // Accumulator destination codes
  localparam int DST_W   = 5;
  localparam int DST_B   = 0;
  localparam int DST_COF = 4;
  localparam int DST_DET = 13;
  localparam int DST_NUM = 14;

  localparam int NUM_STEPS = 46;
  localparam int STEP_W    = 6;

  typedef struct packed {
    logic             first;
    logic             neg;
    logic             last;
    logic [DST_W-1:0] dest;
  } mac_ctl_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel_a;
    logic [SEL_W-1:0] sel_b;
    mac_ctl_t         ctl;
  } step_t;

  typedef logic [NUM_STEPS-1:0][$bits(step_t)-1:0] prog_t;

  // Microprogram: one product per step
  function automatic step_t step_op(input logic [STEP_W-1:0] s);
    int    n;
    int    i;
    int    k;
    int    c;
    int    h;
    step_t op;
    op = '0;
    n  = int'(s);
    if (n < 16) begin
      // b(i) = d^2 - x^2 - y^2 - z^2
      i = n / 4;
      k = n % 4;
      if (k == 0) begin
        op.sel_a = SEL_W'(SEL_ANC + 4 * i + 3);
      end else begin
        op.sel_a   = SEL_W'(SEL_ANC + 4 * i + k - 1);
        op.ctl.neg = 1'b1;
      end
      op.sel_b     = op.sel_a;
      op.ctl.first = (k == 0);
      op.ctl.last  = (k == 3);
      op.ctl.dest  = DST_W'(DST_B + i);
    end else if (n < 34) begin
      // cofactors, two products each
      c = (n - 16) / 2;
      h = (n - 16) % 2;
      i = c / 3;
      k = c % 3;
      if (h == 0) begin
        op.sel_a     = SEL_W'(SEL_M + 3 * ((i + 1) % 3) + (k + 1) % 3);
        op.sel_b     = SEL_W'(SEL_M + 3 * ((i + 2) % 3) + (k + 2) % 3);
        op.ctl.first = 1'b1;
      end else begin
        op.sel_a    = SEL_W'(SEL_M + 3 * ((i + 1) % 3) + (k + 2) % 3);
        op.sel_b    = SEL_W'(SEL_M + 3 * ((i + 2) % 3) + (k + 1) % 3);
        op.ctl.neg  = 1'b1;
        op.ctl.last = 1'b1;
      end
      op.ctl.dest = DST_W'(DST_COF + c);
    end else if (n < 37) begin
      // determinant along the first column
      i            = n - 34;
      op.sel_a     = SEL_W'(SEL_M + 3 * i);
      op.sel_b     = SEL_W'(SEL_COF + 3 * i);
      op.ctl.first = (i == 0);
      op.ctl.last  = (i == 2);
      op.ctl.dest  = DST_W'(DST_DET);
    end else begin
      // numerators det_k = sum r(i) * cof(i,k)
      i            = (n - 37) % 3;
      k            = (n - 37) / 3;
      op.sel_a     = SEL_W'(SEL_R + i);
      op.sel_b     = SEL_W'(SEL_COF + 3 * i + k);
      op.ctl.first = (i == 0);
      op.ctl.last  = (i == 2);
      op.ctl.dest  = DST_W'(DST_NUM + k);
    end
    return op;
  endfunction

  // Whole microprogram as a constant table, built at elaboration
  function automatic prog_t build_prog();
    prog_t p;
    for (int s = 0; s < NUM_STEPS; s++) begin
      p[s] = step_op(STEP_W'(s));
    end
    return p;
  endfunction

  localparam prog_t MAC_PROG = build_prog();

endpackage

// ===== rtl/tps_mac.sv =====
// ----------------------------------------------------------------------------
// tps_mac
// Shared signed multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module tps_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               issue_i,
  input  tps_pkg::mac_ctl_t                  ctl_i,
  input  logic signed [tps_pkg::OPND_W-1:0]  a_i,
  input  logic signed [tps_pkg::OPND_W-1:0]  b_i,
  output logic                               wr_o,
  output logic [tps_pkg::DST_W-1:0]          dest_o,
  output logic signed [tps_pkg::ACC_W-1:0]   res_o
);
  import tps_pkg::*;

  logic                    valid_q;
  mac_ctl_t                ctl_q;
  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= a_i * b_i;
      ctl_q  <= ctl_i;
    end
    if (valid_q) begin
      acc_q <= acc_d;
    end
  end

  // accumulate stage
  always_comb begin
    acc_d = (ctl_q.first ? '0 : acc_q) + (ctl_q.neg ? -prod_q : prod_q);
  end

  assign wr_o   = valid_q & ctl_q.last;
  assign dest_o = ctl_q.dest;
  assign res_o  = acc_d;

endmodule

// ===== rtl/tps_div.sv =====
// ----------------------------------------------------------------------------
// tps_div
// Restoring divider, one quotient bit per cycle, truncating toward zero and
// saturating the quotient to the signed position range.
// ----------------------------------------------------------------------------
module tps_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [tps_pkg::ACC_W-1:0]   num_i,
  input  logic signed [tps_pkg::DEN_W-1:0]   den_i,
  output logic                               done_o,
  output logic [tps_pkg::POS_W-1:0]          quo_o
);
  import tps_pkg::*;

  localparam int SH_W = DEN_W + POS_W;
  localparam int CW   = $clog2(QUO_W);
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] NEG_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [ACC_W-1:0] rem_q;
  logic [SH_W-1:0]  dsh_q;
  logic [QUO_W-1:0] q_q;
  logic             neg_q;
  logic [DEN_W-1:0] dmag;
  logic             ge;

  assign dmag = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
  assign ge   = SH_W'(rem_q) >= dsh_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: compare, subtract, shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
      dsh_q <= {dmag, {POS_W{1'b0}}};
      q_q   <= '0;
      neg_q <= num_i[ACC_W-1] ^ den_i[DEN_W-1];
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q[ACC_W-1:0];
      end
      q_q   <= {q_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  // sign and saturation
  always_comb begin
    if (q_q[QUO_W-1]) begin
      quo_o = neg_q ? NEG_MIN : POS_MAX;
    end else if (neg_q) begin
      quo_o = (q_q[POS_W-1:0] > NEG_MIN) ? NEG_MIN : POS_W'(-q_q[POS_W-1:0]);
    end else begin
      quo_o = q_q[POS_W-1] ? POS_MAX : q_q[POS_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/trilateration_position_solver.sv =====
// ----------------------------------------------------------------------------
// trilateration_position_solver
// Collects anchors, then solves the linearized sphere equations of the first
// four by Cramer's rule on one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// Non-final anchor: taken back to back.
// Final anchor with a count error: S_DONE is entered, then the output register is loaded.
// Final anchor with a solve: 46 multiplier steps, then three 25-step divisions;
// no anchor is taken meanwhile.
// Reset clears the anchor count and the output valid; stored anchors hold junk.
module trilateration_position_solver #(
  parameter int MAX_ANCHORS = tps_pkg::DEF_MAX_ANCHORS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tps_pkg::COORD_W-1:0]  anchor_x_i,
  input  logic signed [tps_pkg::COORD_W-1:0]  anchor_y_i,
  input  logic signed [tps_pkg::COORD_W-1:0]  anchor_z_i,
  input  logic [tps_pkg::DIST_W-1:0]          distance_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tps_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [tps_pkg::POS_W-1:0]    pos_y_o,
  output logic signed [tps_pkg::POS_W-1:0]    pos_z_o,
  output logic [tps_pkg::STAT_W-1:0]          status_o
);
  import tps_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // control state
  logic [2:0]        state_q;
  logic [CNT_W-1:0]  count_q;
  logic [STEP_W-1:0] step_q;
  logic [1:0]        k_q;
  logic [STAT_W-1:0] stat_q;
  logic              out_valid_q;

  // storage
  logic signed [COORD_W-1:0] anc_p_q [USED_ANCHORS][3];
  logic [DIST_W-1:0]         anc_d_q [USED_ANCHORS];
  logic signed [BVAL_W-1:0]  b_q     [USED_ANCHORS];
  logic signed [BVAL_W-1:0]  cof_q   [9];
  logic signed [DET_W-1:0]   det_q;
  logic signed [ACC_W-1:0]   num_q   [3];
  logic [POS_W-1:0]          pos_q   [3];
  logic [POS_W-1:0]          out_x_q;
  logic [POS_W-1:0]          out_y_q;
  logic [POS_W-1:0]          out_z_q;
  logic [STAT_W-1:0]         out_stat_q;

  logic                     in_xfer;
  logic                     out_free;
  logic                     out_load;
  logic [CNT_W-1:0]         cnt_next;
  logic                     issue;
  step_t                    op;
  logic signed [DIFF_W-1:0] m_w [3][3];
  logic signed [BVAL_W-1:0] r_w [3];
  logic signed [OPND_W-1:0] src [NUM_SRC];
  logic signed [OPND_W-1:0] opnd_a;
  logic signed [OPND_W-1:0] opnd_b;
  logic                     mac_wr;
  logic [DST_W-1:0]         mac_dest;
  logic signed [ACC_W-1:0]  mac_res;
  logic                     div_start;
  logic                     div_done;
  logic [POS_W-1:0]         div_quo;

  // handshake and strobes
  assign in_stall_o  = state_q != S_IDLE;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_load    = (state_q == S_DONE) & out_free;
  assign cnt_next    = (count_q == CNT_SAT) ? count_q : count_q + 1'b1;
  assign issue       = state_q == S_RUN;
  assign div_start   = state_q == S_DSTART;
  assign op          = step_t'(MAC_PROG[step_q]);

  // linear system terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_w[i][j] = DIFF_W'(anc_p_q[0][j]) - DIFF_W'(anc_p_q[i+1][j]);
      end
      r_w[i] = b_q[i+1] - b_q[0];
    end
  end

  // operand sources for the shared multiplier
  always_comb begin
    for (int i = 0; i < USED_ANCHORS; i++) begin
      for (int j = 0; j < 3; j++) begin
        src[SEL_ANC + 4*i + j] = OPND_W'(anc_p_q[i][j]);
      end
      src[SEL_ANC + 4*i + 3] = OPND_W'({1'b0, anc_d_q[i]});
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        src[SEL_M + 3*i + j]   = OPND_W'(m_w[i][j]);
        src[SEL_COF + 3*i + j] = OPND_W'(cof_q[3*i + j]);
      end
      src[SEL_R + i] = OPND_W'(r_w[i]);
    end
  end

  assign opnd_a = src[op.sel_a];
  assign opnd_b = src[op.sel_b];

  tps_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .ctl_i   (op.ctl),
    .a_i     (opnd_a),
    .b_i     (opnd_b),
    .wr_o    (mac_wr),
    .dest_o  (mac_dest),
    .res_o   (mac_res)
  );

  tps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q[k_q]),
    .den_i   ({det_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      k_q         <= '0;
      stat_q      <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (last_i) begin
              count_q <= '0;
              if (cnt_next < CNT_W'(USED_ANCHORS)) begin
                stat_q  <= STAT_NOT_ENOUGH;
                state_q <= S_DONE;
              end else if (cnt_next >= CNT_W'(MAX_ANCHORS)) begin
                stat_q  <= STAT_TOO_MANY;
                state_q <= S_DONE;
              end else begin
                step_q  <= '0;
                state_q <= S_RUN;
              end
            end else begin
              count_q <= cnt_next;
            end
          end
        end
        S_RUN: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(NUM_STEPS - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (det_q == '0) begin
            stat_q  <= STAT_DEGENERATE;
            state_q <= S_DONE;
          end else begin
            k_q     <= '0;
            state_q <= S_DSTART;
          end
        end
        S_DSTART: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (k_q == 2'd2) begin
              stat_q  <= STAT_OK;
              state_q <= S_DONE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_DSTART;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    // anchor capture, first four of a solve
    if (in_xfer && count_q < CNT_W'(USED_ANCHORS)) begin
      anc_p_q[count_q[1:0]][0] <= anchor_x_i;
      anc_p_q[count_q[1:0]][1] <= anchor_y_i;
      anc_p_q[count_q[1:0]][2] <= anchor_z_i;
      anc_d_q[count_q[1:0]]    <= distance_i;
    end
    // accumulator write-back
    if (mac_wr) begin
      if (mac_dest < DST_W'(DST_COF)) begin
        b_q[mac_dest[1:0]] <= mac_res[BVAL_W-1:0];
      end else if (mac_dest < DST_W'(DST_DET)) begin
        cof_q[4'(mac_dest - DST_W'(DST_COF))] <= mac_res[BVAL_W-1:0];
      end else if (mac_dest == DST_W'(DST_DET)) begin
        det_q <= mac_res[DET_W-1:0];
      end else begin
        num_q[2'(mac_dest - DST_W'(DST_NUM))] <= mac_res;
      end
    end
    // quotient capture
    if (state_q == S_DIV && div_done) begin
      pos_q[k_q] <= div_quo;
    end
    // output register
    if (out_load) begin
      out_x_q    <= (stat_q == STAT_OK) ? pos_q[0] : '0;
      out_y_q    <= (stat_q == STAT_OK) ? pos_q[1] : '0;
      out_z_q    <= (stat_q == STAT_OK) ? pos_q[2] : '0;
      out_stat_q <= stat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign pos_z_o     = out_z_q;
  assign status_o    = out_stat_q;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the four-anchor trilateration solver. It streams anchor
// transfers with random gaps and output stalls, and predicts every result:
// the status from the anchor count, the position by an exact integer Cramer
// solve. Each result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import tps_pkg::*;

  localparam int MAX_ANC = DEF_MAX_ANCHORS;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [STAT_W-1:0]       st;
  } fix_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [COORD_W-1:0]  ax, ay, az;
  logic [DIST_W-1:0]          distance;
  logic                       last;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [POS_W-1:0]    px, py, pz;
  logic [STAT_W-1:0]          status;

  // predictor state
  longint  anc_x[USED_ANCHORS], anc_y[USED_ANCHORS], anc_z[USED_ANCHORS];
  longint  anc_d[USED_ANCHORS];
  int      anc_cnt;
  fix_t    pending_fixes[$];

  int      errors;
  int      n_ok, n_few, n_many, n_degen;
  bit      gap_en;
  bit      stall_en;
  bit      hold_req;
  int      hold_cnt;

  trilateration_position_solver #(.MAX_ANCHORS(MAX_ANC)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .anchor_x_i(ax), .anchor_y_i(ay), .anchor_z_i(az),
    .distance_i(distance), .last_i(last),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pos_x_o(px), .pos_y_o(py), .pos_z_o(pz), .status_o(status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Quotient of the Cramer numerator by 2*det, truncated, clamped to 24 bits
  function automatic logic signed [POS_W-1:0] clamp_div(logic signed [127:0] num,
                                                         logic signed [127:0] den);
    logic signed [127:0] q;
    q = num / den;
    if (q > 8388607) return 24'sh7FFFFF;
    if (q < -8388608) return 24'sh800000;
    return q[POS_W-1:0];
  endfunction

  // Exact solve of the linearized sphere equations over the stored anchors
  function automatic fix_t solve_fix();
    fix_t   f;
    longint b[USED_ANCHORS];
    longint m[3][3], cof[3][3], r[3], det;
    longint p[USED_ANCHORS][3];
    logic signed [127:0] acc, t1, t2;
    f = '{0, 0, 0, STAT_OK};
    for (int i = 0; i < USED_ANCHORS; i++) begin
      p[i][0] = anc_x[i];
      p[i][1] = anc_y[i];
      p[i][2] = anc_z[i];
      b[i] = anc_d[i] * anc_d[i] - p[i][0] * p[i][0] - p[i][1] * p[i][1]
             - p[i][2] * p[i][2];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) m[i][j] = p[0][j] - p[i+1][j];
      r[i] = b[i+1] - b[0];
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        cof[i][k] = m[(i+1)%3][(k+1)%3] * m[(i+2)%3][(k+2)%3]
                  - m[(i+1)%3][(k+2)%3] * m[(i+2)%3][(k+1)%3];
    det = 0;
    for (int i = 0; i < 3; i++) det += m[i][0] * cof[i][0];
    if (det == 0) begin
      f.st = STAT_DEGENERATE;
      return f;
    end
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        t1 = r[i];
        t2 = cof[i][k];
        acc += t1 * t2;
      end
      t1 = 2 * det;
      if (k == 0) f.x = clamp_div(acc, t1);
      else if (k == 1) f.y = clamp_div(acc, t1);
      else f.z = clamp_div(acc, t1);
    end
    return f;
  endfunction

  // Update the predictor with one accepted anchor
  task automatic predict_anchor(input logic signed [COORD_W-1:0] x, y, z,
                                input logic [DIST_W-1:0] d, input logic l);
    fix_t f;
    if (anc_cnt < USED_ANCHORS) begin
      anc_x[anc_cnt] = x;
      anc_y[anc_cnt] = y;
      anc_z[anc_cnt] = z;
      anc_d[anc_cnt] = longint'(d);
    end
    if (anc_cnt < 31) anc_cnt++;
    if (l) begin
      f = '{0, 0, 0, STAT_OK};
      if (anc_cnt < USED_ANCHORS) f.st = STAT_NOT_ENOUGH;
      else if (anc_cnt >= MAX_ANC) f.st = STAT_TOO_MANY;
      else f = solve_fix();
      anc_cnt = 0;
      pending_fixes.push_back(f);
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!gap_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Drive one anchor transfer and wait until it is taken
  task automatic send_anchor(input logic signed [COORD_W-1:0] x, y, z,
                             input logic [DIST_W-1:0] d, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    ax <= x;
    ay <= y;
    az <= z;
    distance <= d;
    last <= l;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_anchor(x, y, z, d, l);
  endtask

  function automatic logic signed [COORD_W-1:0] rnd_coord();
    return COORD_W'($urandom());
  endfunction

  // A full solve of n anchors with random content
  task automatic send_solve(input int n, input bit flat);
    logic signed [COORD_W-1:0] zc;
    zc = rnd_coord();
    for (int i = 0; i < n; i++)
      send_anchor(rnd_coord(), rnd_coord(), flat ? zc : rnd_coord(),
                  DIST_W'($urandom()), i == n - 1);
  endtask

  task automatic test_anchor_counts();
    // too few, exact, extra anchors, too many, and a count that saturates
    int counts[12] = '{1, 2, 3, 4, 5, 15, 16, 17, 31, 33, 1, 4};
    foreach (counts[i]) send_solve(counts[i], 1'b0);
  endtask

  task automatic test_geometry_cases();
    // unit tetrahedron with a far range: huge negative quotient
    send_anchor(0, 0, 0, 0, 0);
    send_anchor(1, 0, 0, 16'hFFFF, 0);
    send_anchor(0, 1, 0, 16'hFFFF, 0);
    send_anchor(0, 0, 1, 16'hFFFF, 1);
    // same, ranges swapped: huge positive quotient
    send_anchor(0, 0, 0, 16'hFFFF, 0);
    send_anchor(1, 0, 0, 0, 0);
    send_anchor(0, 1, 0, 0, 0);
    send_anchor(0, 0, 1, 0, 1);
    // all anchors on one point: zero determinant
    repeat (3) send_anchor(-32768, 32767, -32768, 16'hFFFF, 0);
    send_anchor(-32768, 32767, -32768, 16'hFFFF, 1);
    // corners of the coordinate range
    send_anchor(-32768, -32768, -32768, 0, 0);
    send_anchor(32767, -32768, -32768, 16'hFFFF, 0);
    send_anchor(-32768, 32767, -32768, 16'h8000, 0);
    send_anchor(-32768, -32768, 32767, 16'h7FFF, 1);
    // a plain well-conditioned layout
    send_anchor(0, 0, 0, 707, 0);
    send_anchor(1000, 0, 0, 860, 0);
    send_anchor(0, 1000, 0, 806, 0);
    send_anchor(0, 0, 1000, 768, 1);
  endtask

  task automatic test_random_solves(input int items);
    int sent;
    int r;
    int n;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 65) n = 4;
      else if (r < 75) n = $urandom_range(1, 3);
      else if (r < 87) n = $urandom_range(5, MAX_ANC - 1);
      else if (r < 95) n = $urandom_range(MAX_ANC, MAX_ANC + 4);
      else n = $urandom_range(28, 40);
      send_solve(n, $urandom_range(0, 9) == 0);
      sent += n;
      // alternate stretches with and without idling
      if ($urandom_range(0, 19) == 0) begin
        gap_en = ~gap_en;
        stall_en = ~stall_en;
      end
    end
  endtask

  task automatic test_output_holdoff();
    hold_req = 1'b1;
    repeat (4) send_solve(4, 1'b0);
    send_solve(2, 1'b0);
  endtask

  // Output stall: random gaps, or a long counted hold when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (stall_en) begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    fix_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d st=%0d",
                 $time, px, py, pz, status);
        errors++;
      end else begin
        e = pending_fixes.pop_front();
        case (e.st)
          STAT_OK:         n_ok++;
          STAT_NOT_ENOUGH: n_few++;
          STAT_TOO_MANY:   n_many++;
          default:         n_degen++;
        endcase
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (px !== e.x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, e.x, px);
          errors++;
        end
        if (py !== e.y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, e.y, py);
          errors++;
        end
        if (pz !== e.z) begin
          $display("%0t: pos_z expected %0d actual %0d", $time, e.z, pz);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    errors = 0;
    n_ok = 0;
    n_few = 0;
    n_many = 0;
    n_degen = 0;
    anc_cnt = 0;
    gap_en = 1'b1;
    stall_en = 1'b1;
    hold_req = 1'b0;
    in_valid = 1'b0;
    ax = '0;
    ay = '0;
    az = '0;
    distance = '0;
    last = 1'b0;
    out_stall = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_anchor_counts();
    test_geometry_cases();
    test_output_holdoff();
    test_random_solves(980);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_fixes.size() == 0);
    repeat (200) @(posedge clk);

    $display("results: %0d solved, %0d short, %0d overlong, %0d degenerate",
             n_ok, n_few, n_many, n_degen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
